// ===== design/multi_channel_watchdog_assert.svh =====
// Assertion macros shared by the watchdog checker.
`ifndef MULTI_CHANNEL_WATCHDOG_ASSERT_SVH
`define MULTI_CHANNEL_WATCHDOG_ASSERT_SVH

// Checked only while reset is low.
`define MCW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("watchdog assertion failed");

// Checked at every clock edge, reset included.
`define MCW_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("watchdog assertion failed");

`endif

// ===== design/mcw_pkg.sv =====
// Shared types and constants of the multi-channel watchdog.
`timescale 1ns / 1ps

package mcw_pkg;

   localparam int CHANNELS_DEF    = 16;
   localparam int COUNT_WIDTH_DEF = 16;

   // Width of a channel number carried along the chain, enough for 64 channels.
   localparam int TOKEN_IDX_W = 6;

   localparam logic [2:0] ACT_ALLOC = 3'd0;
   localparam logic [2:0] ACT_SET   = 3'd1;
   localparam logic [2:0] ACT_FEED  = 3'd2;
   localparam logic [2:0] ACT_CLOSE = 3'd3;
   localparam logic [2:0] ACT_TICK  = 3'd4;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ALLOC,
      OP_SET,
      OP_FEED,
      OP_CLOSE,
      OP_TICK
   } op_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  channel;
      logic [15:0] limit;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [3:0] granted_channel;
      logic       kick;
      logic       expired;
      logic [3:0] expired_channel;
   } rsp_type;

   typedef struct packed {
      logic                   valid;
      logic                   done;
      logic [TOKEN_IDX_W-1:0] idx;
   } tok_type;

endpackage

// ===== design/mcw_stream_if.sv =====
// Valid/ready channel interface carrying one item payload.
`timescale 1ns / 1ps

interface mcw_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== design/mcw_cell.sv =====
// One watchdog channel cell: in-use bit, elapsed count and limit.
`timescale 1ns / 1ps

module mcw_cell #(
   parameter int INDEX       = 0,
   parameter int COUNT_WIDTH = mcw_pkg::COUNT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mcw_pkg::op_type                op,
   input  logic [mcw_pkg::TOKEN_IDX_W-1:0] sel,
   input  logic [COUNT_WIDTH-1:0]         lim_val,
   input  mcw_pkg::tok_type               tok_in,
   output mcw_pkg::tok_type               tok_out
);
   import mcw_pkg::*;

   localparam logic [TOKEN_IDX_W-1:0] INDEX_C = TOKEN_IDX_W'(INDEX);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   logic                   in_use_ff, in_use_in;
   logic [COUNT_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [COUNT_WIDTH-1:0] limit_ff, limit_in;
   tok_type                tok_ff, tok_in_next;

   always_comb begin
      in_use_in   = in_use_ff;
      elapsed_in  = elapsed_ff;
      limit_in    = limit_ff;
      tok_in_next = tok_in;
      if (tok_in.valid) begin
         unique case (op)
            OP_ALLOC: begin
               if (!tok_in.done && !in_use_ff) begin
                  in_use_in        = 1'b1;
                  tok_in_next.done = 1'b1;
                  tok_in_next.idx  = INDEX_C;
               end
            end
            OP_SET: begin
               if (sel == INDEX_C) begin
                  limit_in   = lim_val;
                  elapsed_in = '0;
               end
            end
            OP_FEED: begin
               if (sel == INDEX_C) begin
                  elapsed_in = '0;
               end
            end
            OP_CLOSE: begin
               if (sel == INDEX_C) begin
                  in_use_in = 1'b0;
               end
            end
            OP_TICK: begin
               if (!tok_in.done && in_use_ff) begin
                  if (limit_ff != '0 && elapsed_ff >= limit_ff) begin
                     tok_in_next.done = 1'b1;
                     tok_in_next.idx  = INDEX_C;
                  end else if (elapsed_ff != CNT_MAX) begin
                     elapsed_in = elapsed_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff  <= 1'b0;
         elapsed_ff <= '0;
         limit_ff   <= '0;
         tok_ff     <= '0;
      end else begin
         in_use_ff  <= in_use_in;
         elapsed_ff <= elapsed_in;
         limit_ff   <= limit_in;
         tok_ff     <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== design/multi_channel_watchdog.sv =====
// Top level of the multi-channel watchdog: request decode and the row of channel cells.
`timescale 1ns / 1ps

// Every request item is carried from acceptance to its result by a token that walks the
// row of channel cells, one cell per cycle, and each cell acts on the request as the
// token passes. Allocate grants the lowest free channel, a tick advances and checks the
// channels in ascending order up to the first one that has expired, and set, feed and
// close act on the addressed cell. One item is in work at a time; the result sits in an
// output register, so a new item may be accepted before the previous result is taken.
// Expiry is sticky until reset.

module multi_channel_watchdog #(
   parameter int CHANNELS    = mcw_pkg::CHANNELS_DEF,
   parameter int COUNT_WIDTH = mcw_pkg::COUNT_WIDTH_DEF
) (
   input logic         clock,
   input logic         reset,
   mcw_stream_if.sink   req_chan,
   mcw_stream_if.source rsp_chan
);
   import mcw_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   state_type              state_ff, state_in;
   logic                   start_ff, start_in;
   op_type                 op_ff, op_in;
   logic [TOKEN_IDX_W-1:0] sel_ff, sel_in;
   logic [COUNT_WIDTH-1:0] lim_ff, lim_in;
   logic                   status_ff, status_in;
   logic                   expired_ff, expired_in;
   logic [3:0]             expired_idx_ff, expired_idx_in;
   rsp_type                res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   tok_type                tok_chain [CHANNELS+1];
   tok_type                last_tok;
   req_type                req_data;
   logic [6:0]             chan_ext;
   logic                   ch_ok;
   logic [COUNT_WIDTH-1:0] lim_sat;
   logic                   rsp_free;
   logic                   exp_now;
   rsp_type                result;

   assign req_data = req_chan.data;
   assign last_tok = tok_chain[CHANNELS];

   assign tok_chain[0].valid = start_ff;
   assign tok_chain[0].done  = 1'b0;
   assign tok_chain[0].idx   = '0;

   for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
      mcw_cell #(
         .INDEX       (g),
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .op      (op_ff),
         .sel     (sel_ff),
         .lim_val (lim_ff),
         .tok_in  (tok_chain[g]),
         .tok_out (tok_chain[g+1])
      );
   end

   assign chan_ext = 7'(req_data.channel);
   assign ch_ok    = chan_ext < 7'(CHANNELS);
   assign lim_sat  = (32'(req_data.limit) > 32'(CNT_MAX)) ? CNT_MAX
                                                          : COUNT_WIDTH'(req_data.limit);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign exp_now  = (op_ff == OP_TICK) && last_tok.done;

   always_comb begin
      result.status          = (op_ff == OP_ALLOC) ? !last_tok.done : status_ff;
      result.granted_channel = ((op_ff == OP_ALLOC) && last_tok.done) ? last_tok.idx[3:0]
                                                                       : 4'd0;
      result.kick            = (op_ff == OP_TICK) && !last_tok.done;
      result.expired         = expired_ff || exp_now;
      if (exp_now) begin
         result.expired_channel = last_tok.idx[3:0];
      end else if (expired_ff) begin
         result.expired_channel = expired_idx_ff;
      end else begin
         result.expired_channel = 4'd0;
      end
   end

   always_comb begin
      state_in       = state_ff;
      start_in       = 1'b0;
      op_in          = op_ff;
      sel_in         = sel_ff;
      lim_in         = lim_ff;
      status_in      = status_ff;
      expired_in     = expired_ff;
      expired_idx_in = expired_idx_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in    = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               start_in  = 1'b1;
               sel_in    = TOKEN_IDX_W'(chan_ext);
               lim_in    = lim_sat;
               state_in  = ST_WALK;
               op_in     = OP_NONE;
               status_in = 1'b0;
               unique case (req_data.action)
                  ACT_ALLOC: op_in = OP_ALLOC;
                  ACT_SET: begin
                     if (ch_ok && req_data.limit != 16'd0) begin
                        op_in = OP_SET;
                     end else begin
                        status_in = 1'b1;
                     end
                  end
                  ACT_FEED: begin
                     if (ch_ok) begin
                        op_in = OP_FEED;
                     end else begin
                        status_in = 1'b1;
                     end
                  end
                  ACT_CLOSE: begin
                     if (ch_ok) begin
                        op_in = OP_CLOSE;
                     end else begin
                        status_in = 1'b1;
                     end
                  end
                  ACT_TICK: op_in = expired_ff ? OP_NONE : OP_TICK;
                  default: status_in = 1'b1;
               endcase
            end
         end
         ST_WALK: begin
            if (last_tok.valid) begin
               if (exp_now) begin
                  expired_in     = 1'b1;
                  expired_idx_in = last_tok.idx[3:0];
               end
               if (rsp_free) begin
                  rsp_data_in  = result;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  res_in   = result;
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         start_ff       <= 1'b0;
         expired_ff     <= 1'b0;
         expired_idx_ff <= 4'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         start_ff       <= start_in;
         expired_ff     <= expired_in;
         expired_idx_ff <= expired_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      sel_ff      <= sel_in;
      lim_ff      <= lim_in;
      status_ff   <= status_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

// ===== design/mcw_checker.sv =====
// Port-level checker for the multi-channel watchdog and its bind.
`timescale 1ns / 1ps
`include "multi_channel_watchdog_assert.svh"

module mcw_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mcw_pkg::rsp_type rsp_data
);
   import mcw_pkg::*;

   logic seen_expired_ff, seen_expired_in;

   assign seen_expired_in = seen_expired_ff || (rsp_valid && rsp_ready && rsp_data.expired);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_expired_ff <= 1'b0;
      end else begin
         seen_expired_ff <= seen_expired_in;
      end
   end

   `MCW_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid)
   `MCW_ASSERT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
   `MCW_ASSERT(a_one_item_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready)
   `MCW_ASSERT(a_expiry_sticky, clock, reset, rsp_valid && seen_expired_ff |-> rsp_data.expired)
   `MCW_ASSERT(a_kick_clean, clock, reset, rsp_valid && rsp_data.kick |-> !rsp_data.expired && !rsp_data.status)

endmodule

bind multi_channel_watchdog mcw_checker u_mcw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

// ===== test/watchdog_checker.sv =====
// Checker that predicts every watchdog result and compares it with what the block returns.
`timescale 1ns / 1ps

module watchdog_checker (
   input  logic  clock,
   input  logic  reset,
   mcw_stream_if req_mon,
   mcw_stream_if rsp_mon,
   output int    mismatches,
   output int    open_items
);
   import mcw_pkg::*;

   localparam int          NUM_CH    = CHANNELS_DEF;
   localparam logic [15:0] COUNT_MAX = '1;

   logic        ch_in_use  [NUM_CH];
   logic [15:0] ch_elapsed [NUM_CH];
   logic [15:0] ch_limit   [NUM_CH];
   logic        expiry_seen;
   logic [3:0]  expiry_channel;
   rsp_type     pending_responses [$];
   int          result_index;

   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      $display("watchdog mismatch at result %0d: %s is %0d, %0d predicted",
               result_index, what, got_v, want_v);
      mismatches++;
   endtask

   function automatic rsp_type watchdog_response(input req_type item);
      rsp_type r;
      logic    done;
      int      k;
      r    = '0;
      done = 1'b0;
      case (item.action)
         ACT_ALLOC: begin
            r.status = 1'b1;
            for (k = 0; k < NUM_CH; k++) begin
               if (!done && !ch_in_use[k]) begin
                  ch_in_use[k]      = 1'b1;
                  r.granted_channel = 4'(k);
                  r.status          = 1'b0;
                  done              = 1'b1;
               end
            end
         end
         ACT_SET: begin
            if (item.limit == '0) begin
               r.status = 1'b1;
            end else begin
               ch_limit[item.channel]   = item.limit;
               ch_elapsed[item.channel] = '0;
            end
         end
         ACT_FEED: begin
            ch_elapsed[item.channel] = '0;
         end
         ACT_CLOSE: begin
            ch_in_use[item.channel] = 1'b0;
         end
         ACT_TICK: begin
            if (!expiry_seen) begin
               // The scan stops at the first channel that has reached its limit.
               for (k = 0; k < NUM_CH; k++) begin
                  if (!done && ch_in_use[k]) begin
                     if (ch_limit[k] != '0 && ch_elapsed[k] >= ch_limit[k]) begin
                        done           = 1'b1;
                        expiry_seen    = 1'b1;
                        expiry_channel = 4'(k);
                     end else if (ch_elapsed[k] != COUNT_MAX) begin
                        ch_elapsed[k] = ch_elapsed[k] + 16'd1;
                     end
                  end
               end
               r.kick = !done;
            end
         end
         default: begin
            r.status = 1'b1;
         end
      endcase
      r.expired         = expiry_seen;
      r.expired_channel = expiry_seen ? expiry_channel : 4'd0;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      int      k;
      if (reset) begin
         for (k = 0; k < NUM_CH; k++) begin
            ch_in_use[k]  = 1'b0;
            ch_elapsed[k] = '0;
            ch_limit[k]   = '0;
         end
         expiry_seen    = 1'b0;
         expiry_channel = '0;
         pending_responses.delete();
         mismatches   = 0;
         result_index = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.data;
            if (pending_responses.size() == 0) begin
               report_mismatch("unrequested result, status", int'(got.status), 0);
            end else begin
               want = pending_responses.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", int'(got.status), int'(want.status));
               if (got.granted_channel !== want.granted_channel)
                  report_mismatch("granted_channel", int'(got.granted_channel),
                                  int'(want.granted_channel));
               if (got.kick !== want.kick)
                  report_mismatch("kick", int'(got.kick), int'(want.kick));
               if (got.expired !== want.expired)
                  report_mismatch("expired", int'(got.expired), int'(want.expired));
               if (got.expired_channel !== want.expired_channel)
                  report_mismatch("expired_channel", int'(got.expired_channel),
                                  int'(want.expired_channel));
            end
            result_index++;
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_responses.push_back(watchdog_response(req_mon.data));
         end
      end
      open_items = pending_responses.size();
   end

endmodule

// ===== test/tb.sv =====
// Testbench top for the multi-channel watchdog: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module tb;
   import mcw_pkg::*;

   localparam int          NUM_CH            = CHANNELS_DEF;
   localparam int          CYCLE_LIMIT       = 300000;
   localparam int          RANDOM_ITEMS      = 370;
   localparam int          EXPIRY_ITEMS      = 70;
   localparam int          DRAIN_CYCLES      = 40;
   localparam logic [2:0]  ACT_UNKNOWN_FIRST = ACT_TICK + 3'd1;
   localparam logic [2:0]  ACT_UNKNOWN_LAST  = 3'd7;
   localparam logic [15:0] SAFE_LIMIT_MIN    = 16'd256;
   localparam logic [15:0] SHORT_LIMIT_MAX   = 16'd12;

   typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_PERIODIC} ready_mode_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   int             cycle_count;
   int             burst_left;
   int             check_errors;
   int             check_open;
   ready_mode_type ready_mode;
   int             mode_left;

   mcw_stream_if #(.payload_type(req_type)) req_chan ();
   mcw_stream_if #(.payload_type(rsp_type)) rsp_chan ();

   multi_channel_watchdog u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   watchdog_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .mismatches (check_errors),
      .open_items (check_open)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [3:0] any_channel();
      return 4'($urandom_range(0, NUM_CH - 1));
   endfunction

   function automatic logic [15:0] safe_limit();
      return ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(SAFE_LIMIT_MIN, 16'hFFFF));
   endfunction

   function automatic logic [15:0] short_limit();
      return ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, SHORT_LIMIT_MAX));
   endfunction

   task automatic send_req(input logic [2:0] act, input logic [3:0] chan, input logic [15:0] lim);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= '{action: act, channel: chan, limit: lim};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      mode_left      = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 96);
         end
         mode_left--;
         case (ready_mode)
            RDY_ALWAYS:  rsp_chan.ready <= 1'b1;
            RDY_MOSTLY:  rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            RDY_RARELY:  rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            default:     rsp_chan.ready <= (cycle_count % 5 != 0);
         endcase
      end
   end

   initial begin
      int i;
      int pick;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      burst_left     = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: field extremes, every action and the corner cases.
      send_req(ACT_TICK, 4'd0, 16'd0);
      send_req(ACT_SET, 4'd5, 16'hFFFF);
      send_req(ACT_SET, 4'd3, 16'd0);
      send_req(ACT_FEED, 4'd15, 16'hFFFF);
      send_req(ACT_CLOSE, 4'd0, 16'd0);
      for (i = ACT_UNKNOWN_FIRST; i <= ACT_UNKNOWN_LAST; i++) begin
         send_req(3'(i), 4'd15, 16'hFFFF);
      end
      for (i = 0; i <= NUM_CH; i++) begin
         send_req(ACT_ALLOC, 4'(i), 16'(i));
      end
      send_req(ACT_CLOSE, 4'd7, 16'd0);
      send_req(ACT_ALLOC, 4'd0, 16'd0);
      send_req(ACT_TICK, 4'd15, 16'hFFFF);

      // Limits stay well above the number of ticks, so no channel expires yet.
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 15)
            send_req(ACT_ALLOC, any_channel(), 16'($urandom));
         else if (pick < 35)
            send_req(ACT_SET, any_channel(), safe_limit());
         else if (pick < 50)
            send_req(ACT_FEED, any_channel(), 16'($urandom));
         else if (pick < 65)
            send_req(ACT_CLOSE, any_channel(), 16'($urandom));
         else if (pick < 95)
            send_req(ACT_TICK, any_channel(), 16'($urandom));
         else
            send_req(3'($urandom_range(ACT_UNKNOWN_FIRST, ACT_UNKNOWN_LAST)), any_channel(),
                     16'($urandom));
      end

      // Fill every channel, load short limits on some, then mix ticks with other requests so a channel can expire.
      for (i = 0; i < NUM_CH; i++) begin
         send_req(ACT_CLOSE, 4'(i), 16'($urandom));
      end
      for (i = 0; i < NUM_CH; i++) begin
         send_req(ACT_ALLOC, any_channel(), 16'($urandom));
      end
      for (i = 0; i < NUM_CH / 2; i++) begin
         send_req(ACT_SET, any_channel(), 16'($urandom_range(1, SHORT_LIMIT_MAX)));
      end
      for (i = 0; i < EXPIRY_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            send_req(ACT_TICK, any_channel(), 16'($urandom));
         else if (pick < 65)
            send_req(ACT_FEED, any_channel(), 16'($urandom));
         else if (pick < 80)
            send_req(ACT_SET, any_channel(), short_limit());
         else if (pick < 90)
            send_req(ACT_CLOSE, any_channel(), 16'($urandom));
         else if (pick < 95)
            send_req(ACT_ALLOC, any_channel(), 16'($urandom));
         else
            send_req(3'($urandom_range(ACT_UNKNOWN_FIRST, ACT_UNKNOWN_LAST)), any_channel(),
                     16'($urandom));
      end
      req_chan.valid <= 1'b0;

      while (check_open != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (check_errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
